>>> src/gregorian_date_arithmetic_core_assert.svh
// Assertion macros for the date arithmetic core; clk and rst_n come from the using module.
`ifndef GREGORIAN_DATE_ARITHMETIC_CORE_ASSERT_SVH
`define GREGORIAN_DATE_ARITHMETIC_CORE_ASSERT_SVH

// same-cycle implication
`define GDA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/gda_pkg.sv
package gda_pkg;

    localparam int MAX_YEAR = 9999;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;
    localparam int DIFF_W  = 23;

    // serial day number / remainder, internal year
    localparam int SER_W   = 24;
    localparam int IYEAR_W = 16;

    // shared multiplier
    localparam int MUL_A_W     = 15;
    localparam int MUL_B_W     = 13;
    localparam int MUL_W       = MUL_A_W + MUL_B_W;
    localparam int RECIP_SHIFT = 19;
    localparam int QRCP_W      = MUL_W - RECIP_SHIFT;

    localparam logic [MUL_B_W-1:0] RECIP_100  = MUL_B_W'(5243);
    localparam logic [MUL_B_W-1:0] DAYS_YEAR_M = MUL_B_W'(365);

    localparam logic [SER_W-1:0] DAYS_400Y      = SER_W'(146097);
    localparam logic [SER_W-1:0] DAYS_100Y_LEAP = SER_W'(36525);
    localparam logic [SER_W-1:0] DAYS_100Y      = SER_W'(36524);
    localparam logic [SER_W-1:0] DAYS_4Y        = SER_W'(1461);
    localparam logic [SER_W-1:0] DAYS_4Y_SHORT  = SER_W'(1460);
    localparam logic [SER_W-1:0] DAYS_LEAP_YEAR = SER_W'(366);
    localparam logic [SER_W-1:0] DAYS_YEAR      = SER_W'(365);

    localparam logic [IYEAR_W-1:0] MAX_YEAR_V = IYEAR_W'(MAX_YEAR);

    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    typedef enum logic
    {
        OP_DIFF = 1'b0,
        OP_ADD  = 1'b1
    } op_t;

    typedef enum logic [13:0]
    {
        ST_IDLE  = 14'b00000000000001,
        ST_M365  = 14'b00000000000010,
        ST_M100  = 14'b00000000000100,
        ST_M400  = 14'b00000000001000,
        ST_SUM   = 14'b00000000010000,
        ST_LEAP  = 14'b00000000100000,
        ST_POST  = 14'b00000001000000,
        ST_DIV   = 14'b00000010000000,
        ST_CENT  = 14'b00000100000000,
        ST_GRP0  = 14'b00001000000000,
        ST_GRP   = 14'b00010000000000,
        ST_YEAR  = 14'b00100000000000,
        ST_MONTH = 14'b01000000000000,
        ST_DONE  = 14'b10000000000000
    } state_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] days;
        case (m)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

>>> src/gregorian_date_arithmetic_core.sv
// Gregorian date arithmetic core.
// Input channel (in_valid / in_stall): one beat carries an operation and its
// operands. operation = difference gives day_difference = A - B in days,
// saturated to 23 bits signed; operation = add gives the date day_count days
// after A, with overflow set and the date zeroed when the year passes MAX_YEAR.
// Output channel (out_valid / out_stall): one result beat per input beat.
// in_stall is high while an item is being worked; one item at a time.
// Both operations run through one shared multiplier (serial day number, one
// pass per date); an add then goes through one compare/subtract unit which
// strips 400-year blocks (7 steps), centuries (up to 4), 4-year groups (6),
// years (up to 4) and months (up to 12).
// A finished result sits in the output register; a new input beat can be
// taken while it waits. If out_stall holds the previous result, the next one
// waits in its final state until the output register frees.
// Reset is asynchronous and active low; it returns the core to idle with no
// output valid. No clearing pass is needed.

`include "gregorian_date_arithmetic_core_assert.svh"

module gregorian_date_arithmetic_core
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic [gda_pkg::YEAR_W-1:0]          year_a,
    input  logic [gda_pkg::MONTH_W-1:0]         month_a,
    input  logic [gda_pkg::DAY_W-1:0]           day_a,
    input  logic [gda_pkg::YEAR_W-1:0]          year_b,
    input  logic [gda_pkg::MONTH_W-1:0]         month_b,
    input  logic [gda_pkg::DAY_W-1:0]           day_b,
    input  logic [gda_pkg::COUNT_W-1:0]         day_count,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [gda_pkg::YEAR_W-1:0]          year_out,
    output logic [gda_pkg::MONTH_W-1:0]         month_out,
    output logic [gda_pkg::DAY_W-1:0]           day_out,
    output logic signed [gda_pkg::DIFF_W-1:0]   day_difference,
    output logic                                overflow
);

    localparam logic signed [gda_pkg::SER_W:0] DIFF_HI =
        (gda_pkg::SER_W+1)'((2 ** (gda_pkg::DIFF_W - 1)) - 1);
    localparam logic signed [gda_pkg::SER_W:0] DIFF_LO =
        (gda_pkg::SER_W+1)'(-(2 ** (gda_pkg::DIFF_W - 1)));

    gda_pkg::state_t                    state_reg, state_next;
    logic                               out_valid_reg, out_valid_next;

    gda_pkg::op_t                       op_reg, op_next;
    logic [gda_pkg::YEAR_W-1:0]         ya_reg, ya_next, yb_reg, yb_next;
    logic [gda_pkg::MONTH_W-1:0]        ma_reg, ma_next, mb_reg, mb_next;
    logic [gda_pkg::DAY_W-1:0]          da_reg, da_next, db_reg, db_next;
    logic [gda_pkg::COUNT_W-1:0]        cnt_reg, cnt_next;
    logic                               sel_b_reg, sel_b_next;

    logic [gda_pkg::MUL_W-1:0]          mul_reg, mul_next;
    logic [gda_pkg::SER_W-1:0]          acc_reg, acc_next;
    logic [gda_pkg::SER_W-1:0]          sa_reg, sa_next;
    logic                               div100_reg, div100_next;
    logic                               div400_reg, div400_next;

    logic [gda_pkg::IYEAR_W-1:0]        yr_reg, yr_next;
    logic [gda_pkg::MONTH_W-1:0]        mon_reg, mon_next;
    logic [2:0]                         k_reg, k_next;
    logic                               cfirst_reg, cfirst_next;
    logic                               moved_reg, moved_next;
    logic                               yfirst_reg, yfirst_next;
    logic                               leapy_reg, leapy_next;

    logic [gda_pkg::YEAR_W-1:0]         res_year_reg, res_year_next;
    logic [gda_pkg::MONTH_W-1:0]        res_month_reg, res_month_next;
    logic [gda_pkg::DAY_W-1:0]          res_day_reg, res_day_next;
    logic [gda_pkg::DIFF_W-1:0]         res_diff_reg, res_diff_next;
    logic                               res_ovf_reg, res_ovf_next;

    logic [gda_pkg::YEAR_W-1:0]         year_out_reg, year_out_next;
    logic [gda_pkg::MONTH_W-1:0]        month_out_reg, month_out_next;
    logic [gda_pkg::DAY_W-1:0]          day_out_reg, day_out_next;
    logic [gda_pkg::DIFF_W-1:0]         diff_out_reg, diff_out_next;
    logic                               ovf_out_reg, ovf_out_next;

    logic [gda_pkg::YEAR_W-1:0]         cur_y;
    logic [gda_pkg::MONTH_W-1:0]        cur_m;
    logic [gda_pkg::DAY_W-1:0]          cur_d;
    logic [gda_pkg::MUL_A_W-1:0]        y_ext;
    logic [gda_pkg::MUL_A_W-1:0]        mul_a;
    logic [gda_pkg::MUL_B_W-1:0]        mul_b;
    logic [gda_pkg::QRCP_W-1:0]         q_rcp;
    logic [gda_pkg::MUL_A_W-1:0]        q4;
    logic                               serial_leap;
    logic signed [gda_pkg::SER_W:0]     diff_full;
    logic [gda_pkg::SER_W-1:0]          step_len;
    logic [gda_pkg::SER_W-1:0]          month_days;
    logic                               out_free;

    logic                               st_done;
    logic                               date_zero;
    logic                               date_ok;

    assign in_stall       = (state_reg != gda_pkg::ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign year_out       = year_out_reg;
    assign month_out      = month_out_reg;
    assign day_out        = day_out_reg;
    assign day_difference = $signed(diff_out_reg);
    assign overflow       = ovf_out_reg;

    assign out_free = !out_valid_reg || !out_stall;

    // operand of the serial day number
    assign cur_y = sel_b_reg ? yb_reg : ya_reg;
    assign cur_m = sel_b_reg ? mb_reg : ma_reg;
    assign cur_d = sel_b_reg ? db_reg : da_reg;
    assign y_ext = gda_pkg::MUL_A_W'(cur_y);
    assign q4    = (y_ext + gda_pkg::MUL_A_W'(3)) >> 2;
    assign q_rcp = mul_reg[gda_pkg::MUL_W-1:gda_pkg::RECIP_SHIFT];

    assign serial_leap = (cur_y[1:0] == 2'b00) && (!div100_reg || div400_reg);

    // shared multiplier
    always_comb
    begin
        mul_a = y_ext;
        mul_b = gda_pkg::RECIP_100;
        case (state_reg)
            gda_pkg::ST_M365:
            begin
                mul_a = y_ext;
                mul_b = gda_pkg::DAYS_YEAR_M;
            end
            gda_pkg::ST_M100:
            begin
                mul_a = y_ext + gda_pkg::MUL_A_W'(99);
            end
            gda_pkg::ST_M400:
            begin
                mul_a = (y_ext + gda_pkg::MUL_A_W'(399)) >> 2;
            end
            default:
            begin
                mul_a = y_ext;
            end
        endcase
    end

    assign diff_full = $signed({1'b0, sa_reg}) - $signed({1'b0, acc_reg});

    assign month_days = gda_pkg::SER_W'(gda_pkg::month_len(mon_reg,
                            leapy_reg && (mon_reg == gda_pkg::MONTH_FEB)));

    always_comb
    begin
        step_len = gda_pkg::DAYS_YEAR;
        case (state_reg)
            gda_pkg::ST_DIV:  step_len = gda_pkg::DAYS_400Y << k_reg;
            gda_pkg::ST_CENT: step_len = cfirst_reg ? gda_pkg::DAYS_100Y_LEAP
                                                    : gda_pkg::DAYS_100Y;
            gda_pkg::ST_GRP0: step_len = gda_pkg::DAYS_4Y_SHORT;
            gda_pkg::ST_GRP:  step_len = gda_pkg::DAYS_4Y << k_reg;
            gda_pkg::ST_YEAR: step_len = (yfirst_reg && (cfirst_reg || moved_reg))
                                         ? gda_pkg::DAYS_LEAP_YEAR : gda_pkg::DAYS_YEAR;
            default:          step_len = month_days;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        ya_next        = ya_reg;
        ma_next        = ma_reg;
        da_next        = da_reg;
        yb_next        = yb_reg;
        mb_next        = mb_reg;
        db_next        = db_reg;
        cnt_next       = cnt_reg;
        sel_b_next     = sel_b_reg;
        mul_next       = mul_reg;
        acc_next       = acc_reg;
        sa_next        = sa_reg;
        div100_next    = div100_reg;
        div400_next    = div400_reg;
        yr_next        = yr_reg;
        mon_next       = mon_reg;
        k_next         = k_reg;
        cfirst_next    = cfirst_reg;
        moved_next     = moved_reg;
        yfirst_next    = yfirst_reg;
        leapy_next     = leapy_reg;
        res_year_next  = res_year_reg;
        res_month_next = res_month_reg;
        res_day_next   = res_day_reg;
        res_diff_next  = res_diff_reg;
        res_ovf_next   = res_ovf_reg;
        year_out_next  = year_out_reg;
        month_out_next = month_out_reg;
        day_out_next   = day_out_reg;
        diff_out_next  = diff_out_reg;
        ovf_out_next   = ovf_out_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            gda_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = gda_pkg::op_t'(operation);
                    ya_next    = year_a;
                    yb_next    = year_b;
                    ma_next    = (month_a == '0) ? gda_pkg::MONTH_JAN :
                                 (month_a > gda_pkg::MONTH_DEC) ? gda_pkg::MONTH_DEC : month_a;
                    mb_next    = (month_b == '0) ? gda_pkg::MONTH_JAN :
                                 (month_b > gda_pkg::MONTH_DEC) ? gda_pkg::MONTH_DEC : month_b;
                    da_next    = (day_a == '0) ? gda_pkg::DAY_W'(1) : day_a;
                    db_next    = (day_b == '0) ? gda_pkg::DAY_W'(1) : day_b;
                    cnt_next   = day_count;
                    sel_b_next = 1'b0;
                    state_next = gda_pkg::ST_M365;
                end
            end
            gda_pkg::ST_M365:
            begin
                mul_next   = mul_a * mul_b;
                state_next = gda_pkg::ST_M100;
            end
            gda_pkg::ST_M100:
            begin
                mul_next   = mul_a * mul_b;
                acc_next   = gda_pkg::SER_W'(mul_reg) + gda_pkg::SER_W'(q4)
                           + gda_pkg::SER_W'(gda_pkg::before_month(cur_m))
                           + gda_pkg::SER_W'(cur_d);
                state_next = gda_pkg::ST_M400;
            end
            gda_pkg::ST_M400:
            begin
                mul_next    = mul_a * mul_b;
                acc_next    = acc_reg - gda_pkg::SER_W'(q_rcp);
                div100_next = ((gda_pkg::IYEAR_W'(q_rcp) * gda_pkg::IYEAR_W'(100))
                              == gda_pkg::IYEAR_W'(cur_y));
                state_next  = gda_pkg::ST_SUM;
            end
            gda_pkg::ST_SUM:
            begin
                acc_next    = acc_reg + gda_pkg::SER_W'(q_rcp);
                div400_next = ((gda_pkg::IYEAR_W'(q_rcp) * gda_pkg::IYEAR_W'(400))
                              == gda_pkg::IYEAR_W'(cur_y));
                state_next  = gda_pkg::ST_LEAP;
            end
            gda_pkg::ST_LEAP:
            begin
                acc_next   = acc_reg
                           + gda_pkg::SER_W'((cur_m > gda_pkg::MONTH_FEB) && serial_leap);
                state_next = gda_pkg::ST_POST;
            end
            gda_pkg::ST_POST:
            begin
                if (op_reg == gda_pkg::OP_DIFF)
                begin
                    if (!sel_b_reg)
                    begin
                        sa_next    = acc_reg;
                        sel_b_next = 1'b1;
                        state_next = gda_pkg::ST_M365;
                    end
                    else
                    begin
                        if (diff_full > DIFF_HI)
                        begin
                            res_diff_next = DIFF_HI[gda_pkg::DIFF_W-1:0];
                        end
                        else if (diff_full < DIFF_LO)
                        begin
                            res_diff_next = DIFF_LO[gda_pkg::DIFF_W-1:0];
                        end
                        else
                        begin
                            res_diff_next = diff_full[gda_pkg::DIFF_W-1:0];
                        end
                        res_year_next  = ya_reg;
                        res_month_next = '0;
                        res_day_next   = '0;
                        res_ovf_next   = 1'b0;
                        state_next     = gda_pkg::ST_DONE;
                    end
                end
                else
                begin
                    acc_next    = acc_reg + gda_pkg::SER_W'(cnt_reg) - gda_pkg::SER_W'(1);
                    yr_next     = '0;
                    k_next      = 3'd6;
                    cfirst_next = 1'b1;
                    moved_next  = 1'b0;
                    state_next  = gda_pkg::ST_DIV;
                end
            end
            gda_pkg::ST_DIV:
            begin
                if (acc_reg >= step_len)
                begin
                    acc_next = acc_reg - step_len;
                    yr_next  = yr_reg + (gda_pkg::IYEAR_W'(400) << k_reg);
                end
                if (k_reg == 3'd0)
                begin
                    state_next = gda_pkg::ST_CENT;
                end
                else
                begin
                    k_next = k_reg - 3'd1;
                end
            end
            gda_pkg::ST_CENT:
            begin
                if (acc_reg >= step_len)
                begin
                    acc_next    = acc_reg - step_len;
                    yr_next     = yr_reg + gda_pkg::IYEAR_W'(100);
                    cfirst_next = 1'b0;
                end
                else
                begin
                    state_next = gda_pkg::ST_GRP0;
                end
            end
            gda_pkg::ST_GRP0:
            begin
                // century opening on a common year: its first group is a day short
                if (!cfirst_reg && (acc_reg >= step_len))
                begin
                    acc_next   = acc_reg - step_len;
                    yr_next    = yr_reg + gda_pkg::IYEAR_W'(4);
                    moved_next = 1'b1;
                end
                k_next     = 3'd4;
                state_next = gda_pkg::ST_GRP;
            end
            gda_pkg::ST_GRP:
            begin
                if (acc_reg >= step_len)
                begin
                    acc_next   = acc_reg - step_len;
                    yr_next    = yr_reg + (gda_pkg::IYEAR_W'(4) << k_reg);
                    moved_next = 1'b1;
                end
                if (k_reg == 3'd0)
                begin
                    yfirst_next = 1'b1;
                    state_next  = gda_pkg::ST_YEAR;
                end
                else
                begin
                    k_next = k_reg - 3'd1;
                end
            end
            gda_pkg::ST_YEAR:
            begin
                if (acc_reg >= step_len)
                begin
                    acc_next    = acc_reg - step_len;
                    yr_next     = yr_reg + gda_pkg::IYEAR_W'(1);
                    yfirst_next = 1'b0;
                end
                else
                begin
                    leapy_next = yfirst_reg && (cfirst_reg || moved_reg);
                    mon_next   = gda_pkg::MONTH_JAN;
                    state_next = gda_pkg::ST_MONTH;
                end
            end
            gda_pkg::ST_MONTH:
            begin
                if ((acc_reg >= step_len) && (mon_reg != gda_pkg::MONTH_DEC))
                begin
                    acc_next = acc_reg - step_len;
                    mon_next = mon_reg + gda_pkg::MONTH_W'(1);
                end
                else
                begin
                    res_diff_next = '0;
                    if (yr_reg > gda_pkg::MAX_YEAR_V)
                    begin
                        res_year_next  = '0;
                        res_month_next = '0;
                        res_day_next   = '0;
                        res_ovf_next   = 1'b1;
                    end
                    else
                    begin
                        res_year_next  = yr_reg[gda_pkg::YEAR_W-1:0];
                        res_month_next = mon_reg;
                        res_day_next   = acc_reg[gda_pkg::DAY_W-1:0] + gda_pkg::DAY_W'(1);
                        res_ovf_next   = 1'b0;
                    end
                    state_next = gda_pkg::ST_DONE;
                end
            end
            gda_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    year_out_next  = res_year_reg;
                    month_out_next = res_month_reg;
                    day_out_next   = res_day_reg;
                    diff_out_next  = res_diff_reg;
                    ovf_out_next   = res_ovf_reg;
                    out_valid_next = 1'b1;
                    state_next     = gda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gda_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        ya_reg        <= ya_next;
        ma_reg        <= ma_next;
        da_reg        <= da_next;
        yb_reg        <= yb_next;
        mb_reg        <= mb_next;
        db_reg        <= db_next;
        cnt_reg       <= cnt_next;
        sel_b_reg     <= sel_b_next;
        mul_reg       <= mul_next;
        acc_reg       <= acc_next;
        sa_reg        <= sa_next;
        div100_reg    <= div100_next;
        div400_reg    <= div400_next;
        yr_reg        <= yr_next;
        mon_reg       <= mon_next;
        k_reg         <= k_next;
        cfirst_reg    <= cfirst_next;
        moved_reg     <= moved_next;
        yfirst_reg    <= yfirst_next;
        leapy_reg     <= leapy_next;
        res_year_reg  <= res_year_next;
        res_month_reg <= res_month_next;
        res_day_reg   <= res_day_next;
        res_diff_reg  <= res_diff_next;
        res_ovf_reg   <= res_ovf_next;
        year_out_reg  <= year_out_next;
        month_out_reg <= month_out_next;
        day_out_reg   <= day_out_next;
        diff_out_reg  <= diff_out_next;
        ovf_out_reg   <= ovf_out_next;
    end

    assign st_done   = (state_reg == gda_pkg::ST_DONE);
    assign date_zero = (year_out == '0) && (month_out == '0) && (day_out == '0);
    assign date_ok   = (month_out <= gda_pkg::MONTH_DEC) && (day_out != '0)
                       && (day_difference == '0);

    `GDA_ASSERT_NEXT(a_busy_after_beat, in_valid && !in_stall, in_stall, "idle after beat")
    `GDA_ASSERT_IMP(a_valid_from_done, $rose(out_valid), $past(st_done), "stray result")
    `GDA_ASSERT_IMP(a_ovf_zero_date, out_valid && overflow, date_zero, "overflow with date")
    `GDA_ASSERT_IMP(a_diff_only, out_valid && (|day_difference), (month_out == '0), "mixed")
    `GDA_ASSERT_IMP(a_date_range, out_valid && (month_out != '0), date_ok, "bad date")

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int RANDOM_QUERIES = 1400;
    localparam int CALM_TAIL      = 150;
    localparam int QUIET_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 50;
    localparam int SHOWN_FAILURES = 10;
    localparam longint DIFF_MAX   = 4194303;
    localparam longint DIFF_MIN   = -4194304;

    typedef struct packed
    {
        gda_pkg::op_t                op;
        logic [gda_pkg::YEAR_W-1:0]  year_a;
        logic [gda_pkg::MONTH_W-1:0] month_a;
        logic [gda_pkg::DAY_W-1:0]   day_a;
        logic [gda_pkg::YEAR_W-1:0]  year_b;
        logic [gda_pkg::MONTH_W-1:0] month_b;
        logic [gda_pkg::DAY_W-1:0]   day_b;
        logic [gda_pkg::COUNT_W-1:0] day_count;
    } date_query_t;

    typedef struct packed
    {
        logic [gda_pkg::YEAR_W-1:0]  year;
        logic [gda_pkg::MONTH_W-1:0] month;
        logic [gda_pkg::DAY_W-1:0]   day;
        logic [gda_pkg::DIFF_W-1:0]  diff;
        logic                        ovf;
    } date_answer_t;

    logic                              clk;
    logic                              rst_n     = 1'b0;
    logic                              in_valid  = 1'b0;
    logic                              in_stall;
    logic                              operation = 1'b0;
    logic [gda_pkg::YEAR_W-1:0]        year_a    = '0;
    logic [gda_pkg::MONTH_W-1:0]       month_a   = '0;
    logic [gda_pkg::DAY_W-1:0]         day_a     = '0;
    logic [gda_pkg::YEAR_W-1:0]        year_b    = '0;
    logic [gda_pkg::MONTH_W-1:0]       month_b   = '0;
    logic [gda_pkg::DAY_W-1:0]         day_b     = '0;
    logic [gda_pkg::COUNT_W-1:0]       day_count = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [gda_pkg::YEAR_W-1:0]        year_out;
    logic [gda_pkg::MONTH_W-1:0]       month_out;
    logic [gda_pkg::DAY_W-1:0]         day_out;
    logic signed [gda_pkg::DIFF_W-1:0] day_difference;
    logic                              overflow;

    int days_in_month [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int days_before   [1:12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    date_query_t  queries [$];
    date_answer_t answers_due [$];
    date_query_t  held;

    int fail_count   = 0;
    int quiet_cycles = 0;
    int in_gap       = 0;
    int out_gap      = 0;
    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int beats_sent   = 0;

    gregorian_date_arithmetic_core DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .year_a         (year_a),
        .month_a        (month_a),
        .day_a          (day_a),
        .year_b         (year_b),
        .month_b        (month_b),
        .day_b          (day_b),
        .day_count      (day_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .year_out       (year_out),
        .month_out      (month_out),
        .day_out        (day_out),
        .day_difference (day_difference),
        .overflow       (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit leap_year(input longint y);
        return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
    endfunction

    // days since the proleptic epoch, month and day clamped as the core does
    function automatic longint day_number(input longint y,
                                          input logic [gda_pkg::MONTH_W-1:0] m_raw,
                                          input logic [gda_pkg::DAY_W-1:0] d_raw);
        longint m;
        longint d;
        longint s;
        m = (m_raw == 0) ? 1 : (m_raw > 12) ? 12 : longint'(m_raw);
        d = (d_raw == 0) ? 1 : longint'(d_raw);
        s = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + days_before[m] + d;
        if (m > 2 && leap_year(y))
        begin
            s++;
        end
        return s;
    endfunction

    function automatic date_answer_t predict_answer(input date_query_t q);
        date_answer_t a;
        longint serial_a;
        longint delta;
        longint n;
        longint y;
        longint r;
        longint m;
        longint len;
        a = '0;
        serial_a = day_number(longint'(q.year_a), q.month_a, q.day_a);
        if (q.op == gda_pkg::OP_DIFF)
        begin
            delta = serial_a - day_number(longint'(q.year_b), q.month_b, q.day_b);
            if (delta > DIFF_MAX)
            begin
                delta = DIFF_MAX;
            end
            if (delta < DIFF_MIN)
            begin
                delta = DIFF_MIN;
            end
            a.year = q.year_a;
            a.diff = delta[gda_pkg::DIFF_W-1:0];
        end
        else
        begin
            n = serial_a + longint'(q.day_count) - 1;
            y = (n / 146097) * 400;
            r = n % 146097;
            while (r >= (leap_year(y) ? 366 : 365))
            begin
                r -= leap_year(y) ? 366 : 365;
                y++;
            end
            for (m = 1; m < 12; m++)
            begin
                len = days_in_month[m] + ((m == 2 && leap_year(y)) ? 1 : 0);
                if (r < len)
                begin
                    break;
                end
                r -= len;
            end
            if (y > gda_pkg::MAX_YEAR)
            begin
                a.ovf = 1'b1;
            end
            else
            begin
                a.year  = y[gda_pkg::YEAR_W-1:0];
                a.month = m[gda_pkg::MONTH_W-1:0];
                a.day   = gda_pkg::DAY_W'(r + 1);
            end
        end
        return a;
    endfunction

    task automatic queue_query(input gda_pkg::op_t op, input int ya, input int ma,
                               input int da, input int yb, input int mb, input int db,
                               input int cnt);
        date_query_t q;
        q.op        = op;
        q.year_a    = gda_pkg::YEAR_W'(ya);
        q.month_a   = gda_pkg::MONTH_W'(ma);
        q.day_a     = gda_pkg::DAY_W'(da);
        q.year_b    = gda_pkg::YEAR_W'(yb);
        q.month_b   = gda_pkg::MONTH_W'(mb);
        q.day_b     = gda_pkg::DAY_W'(db);
        q.day_count = gda_pkg::COUNT_W'(cnt);
        queries.push_back(q);
    endtask

    // mostly well-formed dates, with century years, leap days and raw noise mixed in
    task automatic pick_date(output logic [gda_pkg::YEAR_W-1:0] y,
                             output logic [gda_pkg::MONTH_W-1:0] m,
                             output logic [gda_pkg::DAY_W-1:0] d);
        int shape;
        int yy;
        int mm;
        shape = $urandom_range(0, 9);
        if (shape == 0)
        begin
            y = gda_pkg::YEAR_W'($urandom_range(0, 16383));
            m = gda_pkg::MONTH_W'($urandom_range(0, 15));
            d = gda_pkg::DAY_W'($urandom_range(0, 31));
        end
        else
        begin
            yy = (shape < 3) ? 100 * $urandom_range(0, 99) + $urandom_range(0, 1) * 99
                             : $urandom_range(1, 9999);
            if (yy == 0)
            begin
                yy = 1;
            end
            if (shape == 3)
            begin
                mm = 2;
                d  = gda_pkg::DAY_W'($urandom_range(27, 29) - ((!leap_year(yy)) ? 1 : 0));
            end
            else
            begin
                mm = $urandom_range(1, 12);
                d  = gda_pkg::DAY_W'($urandom_range(1, days_in_month[mm]
                                     + ((mm == 2 && leap_year(yy)) ? 1 : 0)));
            end
            y = gda_pkg::YEAR_W'(yy);
            m = gda_pkg::MONTH_W'(mm);
        end
    endtask

    task automatic record_failure(input string what);
        fail_count++;
        if (fail_count <= SHOWN_FAILURES)
        begin
            $display("%s", what);
        end
    endtask

    // input side: one beat held until accepted, random bursts of idle between beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                answers_due.push_back(predict_answer(held));
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (queries.size() > CALM_TAIL && $urandom_range(0, 99) < in_idle_pct)
                begin
                    in_gap = $urandom_range(1, 14) - 1;
                    in_valid <= 1'b0;
                end
                else if (queries.size() > 0)
                begin
                    held = queries.pop_front();
                    beats_sent++;
                    if (beats_sent % 64 == 0)
                    begin
                        in_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                        out_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                    end
                    operation <= held.op;
                    year_a    <= held.year_a;
                    month_a   <= held.month_a;
                    day_a     <= held.day_a;
                    year_b    <= held.year_b;
                    month_b   <= held.month_b;
                    day_b     <= held.day_b;
                    day_count <= held.day_count;
                    in_valid  <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: check each accepted beat, then decide the next stall
    always @(posedge clk)
    begin
        date_answer_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    record_failure($sformatf({"unexpected result beat: year %0d month %0d ",
                                              "day %0d diff %0d ovf %0b"},
                                             year_out, month_out, day_out,
                                             day_difference, overflow));
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (year_out !== want.year || month_out !== want.month
                        || day_out !== want.day || day_difference !== want.diff
                        || overflow !== want.ovf)
                    begin
                        record_failure($sformatf({"mismatch: expected year %0d month %0d day %0d ",
                                                  "diff %0d ovf %0b, got year %0d month %0d ",
                                                  "day %0d diff %0d ovf %0b"},
                                                 want.year, want.month, want.day,
                                                 $signed(want.diff), want.ovf,
                                                 year_out, month_out, day_out,
                                                 day_difference, overflow));
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else if (queries.size() > CALM_TAIL && $urandom_range(0, 99) < out_idle_pct)
            begin
                out_gap = $urandom_range(1, 14) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        date_query_t q;
        int k;
        int shape;

        // calendar corners, clamping and saturation
        queue_query(gda_pkg::OP_DIFF, 2000, 2, 29, 2000, 2, 29, 0);
        queue_query(gda_pkg::OP_DIFF, 2024, 3, 1, 2024, 2, 28, 0);
        queue_query(gda_pkg::OP_DIFF, 1900, 3, 1, 1900, 2, 28, 0);
        queue_query(gda_pkg::OP_DIFF, 9999, 12, 31, 1, 1, 1, 0);
        queue_query(gda_pkg::OP_DIFF, 1, 1, 1, 9999, 12, 31, 4194303);
        queue_query(gda_pkg::OP_DIFF, 16383, 15, 31, 0, 0, 0, 0);
        queue_query(gda_pkg::OP_DIFF, 0, 0, 0, 16383, 15, 31, 0);
        queue_query(gda_pkg::OP_DIFF, 0, 3, 1, 0, 2, 28, 0);
        queue_query(gda_pkg::OP_DIFF, 2001, 0, 15, 2001, 1, 15, 0);
        queue_query(gda_pkg::OP_DIFF, 2001, 13, 5, 2001, 12, 5, 0);
        queue_query(gda_pkg::OP_DIFF, 2023, 6, 0, 2023, 6, 1, 0);
        queue_query(gda_pkg::OP_DIFF, 2023, 2, 31, 2023, 3, 3, 0);
        queue_query(gda_pkg::OP_DIFF, 2100, 3, 1, 2000, 3, 1, 0);
        queue_query(gda_pkg::OP_ADD, 2000, 1, 1, 0, 0, 0, 0);
        queue_query(gda_pkg::OP_ADD, 2024, 2, 28, 16383, 15, 31, 1);
        queue_query(gda_pkg::OP_ADD, 1900, 2, 28, 0, 0, 0, 1);
        queue_query(gda_pkg::OP_ADD, 1999, 12, 31, 0, 0, 0, 1);
        queue_query(gda_pkg::OP_ADD, 9999, 12, 30, 0, 0, 0, 1);
        queue_query(gda_pkg::OP_ADD, 9999, 12, 31, 0, 0, 0, 1);
        queue_query(gda_pkg::OP_ADD, 1, 1, 1, 0, 0, 0, 4194303);
        queue_query(gda_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 146097);
        queue_query(gda_pkg::OP_ADD, 16383, 15, 31, 0, 0, 0, 0);
        queue_query(gda_pkg::OP_ADD, 2023, 2, 31, 0, 0, 0, 0);
        queue_query(gda_pkg::OP_ADD, 0, 2, 29, 0, 0, 0, 365);
        queue_query(gda_pkg::OP_ADD, 7000, 1, 1, 0, 0, 0, 1095727);

        for (k = 0; k < RANDOM_QUERIES; k++)
        begin
            q.op = ($urandom_range(0, 1) == 1) ? gda_pkg::OP_ADD : gda_pkg::OP_DIFF;
            pick_date(q.year_a, q.month_a, q.day_a);
            pick_date(q.year_b, q.month_b, q.day_b);
            if (q.op == gda_pkg::OP_DIFF && $urandom_range(0, 3) == 0)
            begin
                q.year_b = q.year_a;
            end
            shape = $urandom_range(0, 9);
            case (shape)
                0:       q.day_count = gda_pkg::COUNT_W'($urandom_range(0, 31));
                1, 2:    q.day_count = gda_pkg::COUNT_W'($urandom_range(0, 1000));
                3, 4, 5: q.day_count = gda_pkg::COUNT_W'($urandom_range(0, 400000));
                6:       q.day_count = gda_pkg::COUNT_W'(146097 * $urandom_range(1, 28)
                                                         - $urandom_range(0, 1));
                default: q.day_count = gda_pkg::COUNT_W'($urandom_range(0, 4194303));
            endcase
            queries.push_back(q);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (queries.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (answers_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> gregorian_date_arithmetic_core.f
+incdir+src
src/gda_pkg.sv
src/gregorian_date_arithmetic_core.sv
tb/tb.sv
